>>> src/svic_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sprite VM instruction core.
// No dependencies; svic_ctrl, svic_dp and the top level import this package.
package svic_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int STACK_DEPTH = 16;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int ADDR_W      = 12;

    localparam logic [ADDR_W-1:0] FONT_BASE = 12'h050;
    localparam logic [ADDR_W-1:0] FONT_END  = 12'h0A0;
    localparam logic [ADDR_W-1:0] START_PC  = 12'h200;

    // 16 glyphs of 5 rows; byte k sits at bits [(79-k)*8 +: 8]
    localparam logic [639:0] FONT_ROM = {
        160'hF0909090F02060202070F010F080F0F010F010F0,
        160'h9090F01010F080F010F0F080F090F0F010204040,
        160'hF090F090F0F090F010F0F090F09090E090E090E0,
        160'hF0808080F0E0909090E0F080F080F0F080F08080
    };

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_STEP = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } command_t;

    // instruction groups, top nibble of the opcode
    localparam logic [3:0] OP_SYS         = 4'h0;
    localparam logic [3:0] OP_JUMP        = 4'h1;
    localparam logic [3:0] OP_CALL        = 4'h2;
    localparam logic [3:0] OP_SKIP_EQ_IMM = 4'h3;
    localparam logic [3:0] OP_SKIP_NE_IMM = 4'h4;
    localparam logic [3:0] OP_SKIP_EQ_REG = 4'h5;
    localparam logic [3:0] OP_SET_IMM     = 4'h6;
    localparam logic [3:0] OP_ADD_IMM     = 4'h7;
    localparam logic [3:0] OP_ALU         = 4'h8;
    localparam logic [3:0] OP_SKIP_NE_REG = 4'h9;
    localparam logic [3:0] OP_SET_INDEX   = 4'hA;
    localparam logic [3:0] OP_JUMP_V0     = 4'hB;
    localparam logic [3:0] OP_RANDOM      = 4'hC;
    localparam logic [3:0] OP_DRAW        = 4'hD;
    localparam logic [3:0] OP_KEY         = 4'hE;
    localparam logic [3:0] OP_MISC        = 4'hF;

    localparam logic [15:0] SYS_CLS = 16'h00E0;
    localparam logic [15:0] SYS_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_RSB = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    localparam logic [7:0] FN_GET_DELAY = 8'h07;
    localparam logic [7:0] FN_WAIT_KEY  = 8'h0A;
    localparam logic [7:0] FN_SET_DELAY = 8'h15;
    localparam logic [7:0] FN_SET_SOUND = 8'h18;
    localparam logic [7:0] FN_ADD_INDEX = 8'h1E;
    localparam logic [7:0] FN_FONT      = 8'h29;
    localparam logic [7:0] FN_BCD       = 8'h33;
    localparam logic [7:0] FN_STORE     = 8'h55;
    localparam logic [7:0] FN_RESTORE   = 8'h65;

    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_CLEAR,
        UOP_CAPTURE,
        UOP_LOAD,
        UOP_FETCH_HI,
        UOP_FETCH_LO,
        UOP_DECODE,
        UOP_READ_X,
        UOP_READ_Y,
        UOP_EXEC,
        UOP_DRAW_RD,
        UOP_DRAW_WR,
        UOP_DRAW_END,
        UOP_BCD,
        UOP_STORE,
        UOP_LOAD_RD,
        UOP_LOAD_WR,
        UOP_TICK,
        UOP_RESULT
    } uop_t;

    typedef struct packed {
        uop_t uop;
        logic result_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       clear_done;
        command_t   command;
        logic [3:0] op_group;
        logic [7:0] nn;
        logic       n_zero;
        logic       draw_stop;
        logic       loop_last;
    } dp_status_t;

endpackage

>>> src/svic_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the sprite VM instruction core: command items,
// result items and the start address write port. No dependencies.
interface svic_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  data_byte;
    logic [15:0] keys;
    logic [7:0]  random_byte;

    modport source (output valid, command, address, data_byte, keys, random_byte,
                    input ready);
    modport sink (input valid, command, address, data_byte, keys, random_byte,
                  output ready);
endinterface

interface svic_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] program_counter;
    logic [15:0] executed_opcode;
    logic [63:0] row_pixels;
    logic        waiting_for_key;
    logic        beep;

    modport source (output valid, program_counter, executed_opcode, row_pixels,
                    waiting_for_key, beep, input ready);
    modport sink (input valid, program_counter, executed_opcode, row_pixels,
                  waiting_for_key, beep, output ready);
endinterface

interface svic_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] boot_pc;

    modport source (output valid, boot_pc, input ready);
    modport sink (input valid, boot_pc, output ready);
endinterface

>>> src/svic_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the sprite VM instruction core: steps each command through
// its micro-operations. Depends on svic_pkg.
module svic_ctrl
    import svic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    output logic       result_valid,
    input  logic       result_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_DECODE,
        ST_READ_X,
        ST_READ_Y,
        ST_EXEC,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_DRAW_END,
        ST_BCD,
        ST_STORE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_TICK,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;
    logic   slot_free;
    logic   item_fire;

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign result_valid = valid_reg;
    assign slot_free    = !valid_reg || result_ready;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg && !result_ready;
        cmd.uop         = UOP_NOP;
        cmd.result_load = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.uop = UOP_CLEAR;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    cmd.uop    = UOP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (status.command)
                    CMD_LOAD: state_next = ST_LOAD;
                    CMD_STEP: state_next = ST_FETCH_HI;
                    default:  state_next = ST_RESULT;
                endcase
            end
            ST_LOAD:
            begin
                cmd.uop    = UOP_LOAD;
                state_next = ST_RESULT;
            end
            ST_FETCH_HI:
            begin
                cmd.uop    = UOP_FETCH_HI;
                state_next = ST_FETCH_LO;
            end
            ST_FETCH_LO:
            begin
                cmd.uop    = UOP_FETCH_LO;
                state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                cmd.uop    = UOP_DECODE;
                state_next = ST_READ_X;
            end
            ST_READ_X:
            begin
                cmd.uop    = UOP_READ_X;
                state_next = ST_READ_Y;
            end
            ST_READ_Y:
            begin
                cmd.uop    = UOP_READ_Y;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.uop    = UOP_EXEC;
                state_next = ST_TICK;
                if (status.op_group == OP_DRAW)
                begin
                    state_next = status.n_zero ? ST_DRAW_END : ST_DRAW_RD;
                end
                else if (status.op_group == OP_MISC)
                begin
                    if (status.nn == FN_BCD)
                    begin
                        state_next = ST_BCD;
                    end
                    else if (status.nn == FN_STORE)
                    begin
                        state_next = ST_STORE;
                    end
                    else if (status.nn == FN_RESTORE)
                    begin
                        state_next = ST_LOAD_RD;
                    end
                end
            end
            ST_DRAW_RD:
            begin
                // stop at the bottom edge of the screen
                if (status.draw_stop)
                begin
                    state_next = ST_DRAW_END;
                end
                else
                begin
                    cmd.uop    = UOP_DRAW_RD;
                    state_next = ST_DRAW_WR;
                end
            end
            ST_DRAW_WR:
            begin
                cmd.uop    = UOP_DRAW_WR;
                state_next = status.loop_last ? ST_DRAW_END : ST_DRAW_RD;
            end
            ST_DRAW_END:
            begin
                cmd.uop    = UOP_DRAW_END;
                state_next = ST_TICK;
            end
            ST_BCD:
            begin
                cmd.uop = UOP_BCD;
                if (status.loop_last)
                begin
                    state_next = ST_TICK;
                end
            end
            ST_STORE:
            begin
                cmd.uop = UOP_STORE;
                if (status.loop_last)
                begin
                    state_next = ST_TICK;
                end
            end
            ST_LOAD_RD:
            begin
                cmd.uop    = UOP_LOAD_RD;
                state_next = ST_LOAD_WR;
            end
            ST_LOAD_WR:
            begin
                cmd.uop    = UOP_LOAD_WR;
                state_next = status.loop_last ? ST_TICK : ST_LOAD_RD;
            end
            ST_TICK:
            begin
                cmd.uop    = UOP_TICK;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    cmd.uop         = UOP_RESULT;
                    cmd.result_load = 1'b1;
                    valid_next      = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

>>> src/svic_dp.sv
`timescale 1ns / 1ps
// Datapath of the sprite VM instruction core: program memory, display rows,
// registers, stack, timers and the result register. Depends on svic_pkg.
module svic_dp
    import svic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic [1:0]  command,
    input  logic [11:0] address,
    input  logic [7:0]  data_byte,
    input  logic [15:0] keys,
    input  logic [7:0]  random_byte,
    input  logic        cfg_write,
    input  logic [11:0] cfg_boot_pc,
    output logic [11:0] program_counter,
    output logic [15:0] executed_opcode,
    output logic [63:0] row_pixels,
    output logic        waiting_for_key,
    output logic        beep
);

    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  rdata_reg;
    logic [11:0] stack [STACK_DEPTH];

    logic [63:0] fb_reg [SCREEN_H];
    logic [7:0]  v_reg [16];
    logic [15:0] i_reg;
    logic [11:0] pc_reg;
    logic [3:0]  sp_reg;
    logic [7:0]  delay_reg;
    logic [7:0]  sound_reg;
    logic [11:0] clr_reg;
    logic [3:0]  step_reg;
    logic        hit_reg;
    logic        wait_reg;
    logic        beep_reg;

    logic [1:0]  cmd_reg;
    logic [11:0] addr_reg;
    logic [7:0]  data_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;
    logic [7:0]  hi_reg;
    logic [15:0] opcode_reg;
    logic [7:0]  vx_reg;
    logic [7:0]  vy_reg;

    logic [11:0] out_pc_reg;
    logic [15:0] out_op_reg;
    logic [63:0] out_row_reg;
    logic        out_wait_reg;
    logic        out_beep_reg;

    logic [3:0]  op_x;
    logic [3:0]  op_y;
    logic [3:0]  op_n;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    logic [3:0]  op_group;
    logic [11:0] i_addr;
    logic [11:0] mem_raddr;
    logic        mem_we;
    logic [11:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic [3:0]  v_rd_idx;
    logic [7:0]  v_rd;
    logic [5:0]  draw_row;
    logic [4:0]  fb_idx;
    logic [63:0] fb_rd;
    logic [63:0] sprite_bits;
    logic [11:0] stack_rd;
    logic [6:0]  font_off;
    logic [7:0]  font_data;
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [3:0]  bcd_t;
    logic [3:0]  bcd_o;
    logic [7:0]  bcd_digit;
    logic [3:0]  first_key;
    logic        any_key;
    logic        key_hit;
    logic [8:0]  add_sum;
    logic        loop_last;

    assign op_x     = opcode_reg[11:8];
    assign op_y     = opcode_reg[7:4];
    assign op_n     = opcode_reg[3:0];
    assign op_nn    = opcode_reg[7:0];
    assign op_nnn   = opcode_reg[11:0];
    assign op_group = opcode_reg[15:12];
    assign i_addr   = i_reg[11:0] + {8'd0, step_reg};

    // font bytes during the clearing sweep
    assign font_off  = 7'(clr_reg - FONT_BASE);
    assign font_data = FONT_ROM[(10'd79 - {3'd0, font_off}) * 10'd8 +: 8];

    // decimal digits of Vx
    always_comb
    begin
        if (vx_reg >= 8'd200)
        begin
            bcd_h = 2'd2;
        end
        else if (vx_reg >= 8'd100)
        begin
            bcd_h = 2'd1;
        end
        else
        begin
            bcd_h = 2'd0;
        end
        bcd_rem = 7'(vx_reg - 8'({bcd_h, 5'd0} + {bcd_h, 2'd0} + {1'b0, bcd_h, 6'd0}));
        bcd_t   = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (bcd_rem >= 7'(k * 10))
            begin
                bcd_t = 4'(k);
            end
        end
        bcd_o = 4'(bcd_rem - 7'({bcd_t, 3'd0} + {bcd_t, 1'b0}));
        case (step_reg)
            4'd0:    bcd_digit = {6'd0, bcd_h};
            4'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = {4'd0, bcd_o};
        endcase
    end

    // lowest numbered key that is down
    always_comb
    begin
        first_key = 4'd0;
        for (int k = 15; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                first_key = 4'(k);
            end
        end
    end
    assign any_key = |keys_reg;
    assign key_hit = keys_reg[vx_reg[3:0]];
    assign add_sum = {1'b0, vx_reg} + {1'b0, vy_reg};

    always_comb
    begin
        case (cmd.uop)
            UOP_FETCH_LO:              mem_raddr = pc_reg + 12'd1;
            UOP_DRAW_RD, UOP_LOAD_RD:  mem_raddr = i_addr;
            default:                   mem_raddr = pc_reg;
        endcase
    end

    always_comb
    begin
        v_rd_idx = op_x;
        case (cmd.uop)
            UOP_READ_Y: v_rd_idx = (op_group == OP_JUMP_V0) ? 4'd0 : op_y;
            UOP_STORE:  v_rd_idx = step_reg;
            default:    v_rd_idx = op_x;
        endcase
    end
    assign v_rd = v_reg[v_rd_idx];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = i_addr;
        mem_wdata = v_rd;
        case (cmd.uop)
            UOP_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg >= FONT_BASE && clr_reg < FONT_END) ? font_data : 8'd0;
            end
            UOP_LOAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = data_reg;
            end
            UOP_BCD:
            begin
                mem_we    = 1'b1;
                mem_wdata = bcd_digit;
            end
            UOP_STORE:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign draw_row    = {1'b0, vy_reg[4:0]} + {2'd0, step_reg};
    assign fb_idx      = (cmd.uop == UOP_RESULT) ? addr_reg[4:0] : draw_row[4:0];
    assign fb_rd       = fb_reg[fb_idx];
    assign sprite_bits = {rdata_reg, 56'd0} >> vx_reg[5:0];
    assign stack_rd    = stack[sp_reg - 4'd1];

    always_comb
    begin
        if (op_group == OP_DRAW)
        begin
            loop_last = (step_reg == op_n - 4'd1);
        end
        else if (op_nn == FN_BCD)
        begin
            loop_last = (step_reg == 4'd2);
        end
        else
        begin
            loop_last = (step_reg == op_x);
        end
    end

    assign status.clear_done = (clr_reg == 12'hFFF);
    assign status.command    = command_t'(cmd_reg);
    assign status.op_group   = op_group;
    assign status.nn         = op_nn;
    assign status.n_zero     = (op_n == 4'd0);
    assign status.draw_stop  = draw_row[5];
    assign status.loop_last  = loop_last;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.uop == UOP_EXEC && op_group == OP_CALL)
        begin
            stack[sp_reg] <= pc_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.uop)
            UOP_CAPTURE:
            begin
                cmd_reg    <= command;
                addr_reg   <= address;
                data_reg   <= data_byte;
                keys_reg   <= keys;
                rnd_reg    <= random_byte;
                opcode_reg <= 16'd0;
            end
            UOP_FETCH_LO: hi_reg     <= rdata_reg;
            UOP_DECODE:   opcode_reg <= {hi_reg, rdata_reg};
            UOP_READ_X:   vx_reg     <= v_rd;
            UOP_READ_Y:   vy_reg     <= v_rd;
            default:
            begin
            end
        endcase
        if (cmd.result_load)
        begin
            out_pc_reg   <= pc_reg;
            out_op_reg   <= opcode_reg;
            out_row_reg  <= (cmd_reg == CMD_READ && addr_reg < 12'(SCREEN_H)) ? fb_rd : 64'd0;
            out_wait_reg <= wait_reg;
            out_beep_reg <= beep_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SCREEN_H; r++)
            begin
                fb_reg[r] <= 64'd0;
            end
            for (int r = 0; r < 16; r++)
            begin
                v_reg[r] <= 8'd0;
            end
            i_reg     <= 16'd0;
            pc_reg    <= START_PC;
            sp_reg    <= 4'd0;
            delay_reg <= 8'd0;
            sound_reg <= 8'd0;
            clr_reg   <= 12'd0;
            step_reg  <= 4'd0;
            hit_reg   <= 1'b0;
            wait_reg  <= 1'b0;
            beep_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                pc_reg <= cfg_boot_pc;
            end
            case (cmd.uop)
                UOP_CLEAR:
                begin
                    clr_reg <= clr_reg + 12'd1;
                end
                UOP_CAPTURE:
                begin
                    wait_reg <= 1'b0;
                    beep_reg <= 1'b0;
                end
                UOP_DECODE:
                begin
                    pc_reg   <= pc_reg + 12'd2;
                    step_reg <= 4'd0;
                    hit_reg  <= 1'b0;
                end
                UOP_EXEC:
                begin
                    case (op_group)
                        OP_SYS:
                        begin
                            if (opcode_reg == SYS_CLS)
                            begin
                                for (int r = 0; r < SCREEN_H; r++)
                                begin
                                    fb_reg[r] <= 64'd0;
                                end
                            end
                            else if (opcode_reg == SYS_RET)
                            begin
                                sp_reg <= sp_reg - 4'd1;
                                pc_reg <= stack_rd;
                            end
                        end
                        OP_JUMP: pc_reg <= op_nnn;
                        OP_CALL:
                        begin
                            sp_reg <= sp_reg + 4'd1;
                            pc_reg <= op_nnn;
                        end
                        OP_SKIP_EQ_IMM:
                        begin
                            if (vx_reg == op_nn)
                            begin
                                pc_reg <= pc_reg + 12'd2;
                            end
                        end
                        OP_SKIP_NE_IMM:
                        begin
                            if (vx_reg != op_nn)
                            begin
                                pc_reg <= pc_reg + 12'd2;
                            end
                        end
                        OP_SKIP_EQ_REG:
                        begin
                            if (vx_reg == vy_reg)
                            begin
                                pc_reg <= pc_reg + 12'd2;
                            end
                        end
                        OP_SKIP_NE_REG:
                        begin
                            if (vx_reg != vy_reg)
                            begin
                                pc_reg <= pc_reg + 12'd2;
                            end
                        end
                        OP_SET_IMM: v_reg[op_x] <= op_nn;
                        OP_ADD_IMM: v_reg[op_x] <= vx_reg + op_nn;
                        OP_ALU:
                        begin
                            // flag first, then Vx, so Vx wins when X is F
                            case (op_n)
                                ALU_MOV: v_reg[op_x] <= vy_reg;
                                ALU_OR:  v_reg[op_x] <= vx_reg | vy_reg;
                                ALU_AND: v_reg[op_x] <= vx_reg & vy_reg;
                                ALU_XOR: v_reg[op_x] <= vx_reg ^ vy_reg;
                                ALU_ADD:
                                begin
                                    v_reg[15]   <= {7'd0, add_sum[8]};
                                    v_reg[op_x] <= add_sum[7:0];
                                end
                                ALU_SUB:
                                begin
                                    v_reg[15]   <= {7'd0, vx_reg >= vy_reg};
                                    v_reg[op_x] <= vx_reg - vy_reg;
                                end
                                ALU_SHR:
                                begin
                                    v_reg[15]   <= {7'd0, vx_reg[0]};
                                    v_reg[op_x] <= {1'b0, vx_reg[7:1]};
                                end
                                ALU_RSB:
                                begin
                                    v_reg[15]   <= {7'd0, vy_reg >= vx_reg};
                                    v_reg[op_x] <= vy_reg - vx_reg;
                                end
                                ALU_SHL:
                                begin
                                    v_reg[15]   <= {7'd0, vx_reg[7]};
                                    v_reg[op_x] <= {vx_reg[6:0], 1'b0};
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        OP_SET_INDEX: i_reg <= {4'd0, op_nnn};
                        OP_JUMP_V0:   pc_reg <= {4'd0, vy_reg} + op_nnn;
                        OP_RANDOM:    v_reg[op_x] <= rnd_reg & op_nn;
                        OP_KEY:
                        begin
                            if ((op_nn == KEY_DOWN && key_hit) || (op_nn == KEY_UP && !key_hit))
                            begin
                                pc_reg <= pc_reg + 12'd2;
                            end
                        end
                        OP_MISC:
                        begin
                            case (op_nn)
                                FN_GET_DELAY: v_reg[op_x] <= delay_reg;
                                FN_WAIT_KEY:
                                begin
                                    if (any_key)
                                    begin
                                        v_reg[op_x] <= {4'd0, first_key};
                                    end
                                    else
                                    begin
                                        pc_reg   <= pc_reg - 12'd2;
                                        wait_reg <= 1'b1;
                                    end
                                end
                                FN_SET_DELAY: delay_reg <= vx_reg;
                                FN_SET_SOUND: sound_reg <= vx_reg;
                                FN_ADD_INDEX: i_reg <= i_reg + {8'd0, vx_reg};
                                FN_FONT:
                                begin
                                    i_reg <= {4'd0, FONT_BASE} + {6'd0, vx_reg, 2'd0}
                                             + {8'd0, vx_reg};
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
                UOP_DRAW_WR:
                begin
                    fb_reg[fb_idx] <= fb_rd ^ sprite_bits;
                    hit_reg        <= hit_reg | (|(fb_rd & sprite_bits));
                    step_reg       <= step_reg + 4'd1;
                end
                UOP_DRAW_END:
                begin
                    v_reg[15] <= {7'd0, hit_reg};
                end
                UOP_BCD, UOP_STORE:
                begin
                    step_reg <= step_reg + 4'd1;
                end
                UOP_LOAD_WR:
                begin
                    v_reg[step_reg] <= rdata_reg;
                    step_reg        <= step_reg + 4'd1;
                end
                UOP_TICK:
                begin
                    if (delay_reg != 8'd0)
                    begin
                        delay_reg <= delay_reg - 8'd1;
                    end
                    if (sound_reg != 8'd0)
                    begin
                        sound_reg <= sound_reg - 8'd1;
                    end
                    beep_reg <= (sound_reg == 8'd1);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign program_counter = out_pc_reg;
    assign executed_opcode = out_op_reg;
    assign row_pixels      = out_row_reg;
    assign waiting_for_key = out_wait_reg;
    assign beep            = out_beep_reg;

endmodule

>>> src/sprite_vm_instruction_core.sv
`timescale 1ns / 1ps
// Top level of the sprite VM instruction core: sequencer plus datapath.
// Depends on svic_pkg, svic_if, svic_ctrl and svic_dp.
//
// CHIP-8 interpreter core taking one command per transaction and returning
// one result per transaction. After reset the core sweeps all of program
// memory, loading the font at 0x050 and zeroing the rest; no command is
// taken during the sweep, but start address writes are. The core works on
// one command at a time through a program memory with one read and one
// write port. A step fetches the opcode high byte then low byte, decodes
// it, reads Vx and Vy and executes it; a draw then reads and writes each
// sprite row in turn, stopping at the bottom edge, and sets the collision
// flag; FX55 and FX33 write one byte at a time and FX65 reads and writes
// each register in turn; last the timers tick.
// A finished result waits in an output register until it is taken.
module sprite_vm_instruction_core
    import svic_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    svic_item_if.sink     item,
    svic_result_if.source result,
    svic_cfg_if.sink      cfg
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    svic_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    svic_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .command           (item.command),
        .address           (item.address),
        .data_byte         (item.data_byte),
        .keys              (item.keys),
        .random_byte       (item.random_byte),
        .cfg_write         (cfg.valid && cfg.ready),
        .cfg_boot_pc       (cfg.boot_pc),
        .program_counter   (result.program_counter),
        .executed_opcode   (result.executed_opcode),
        .row_pixels        (result.row_pixels),
        .waiting_for_key   (result.waiting_for_key),
        .beep              (result.beep)
    );

endmodule
